@@ rtl/bcd_pkg.sv @@
// Shared types, codes and constants of the button click decoder.
package bcd_pkg;

   localparam int TIME_W    = 32;
   localparam int MAX_EDGES = 128;
   localparam int IDX_W     = $clog2(MAX_EDGES);
   localparam int EV_W      = 4;
   localparam int CLK_CNT_W = 6;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [TIME_W-1:0] SHORT_PRESS_RST  = TIME_W'(1000 * 1000);
   localparam logic [TIME_W-1:0] LONG_PRESS_RST   = TIME_W'(3 * 1000 * 1000);
   localparam logic [TIME_W-1:0] REPEAT_GAP_RST   = TIME_W'(200 * 1000);
   localparam logic [TIME_W-1:0] MIN_EDGE_GAP_RST = TIME_W'(5 * 1000);
   localparam logic [TIME_W-1:0] STALL_RST        = TIME_W'(1000 * 1000);

   typedef enum logic [EV_W-1:0] {
      EV_NONE        = 4'd0,
      EV_PRESS       = 4'd1,
      EV_RELEASE     = 4'd2,
      EV_SHORT_START = 4'd3,
      EV_SHORT_END   = 4'd4,
      EV_LONG_START  = 4'd5,
      EV_LONG_HOLD   = 4'd6,
      EV_LONG_END    = 4'd7,
      EV_SINGLE      = 4'd8,
      EV_DOUBLE      = 4'd9,
      EV_TRIPLE      = 4'd10,
      EV_REPEAT      = 4'd11
   } event_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 3'd0,
      ST_GAP   = 3'd1,
      ST_STALL = 3'd2,
      ST_SAME  = 3'd3,
      ST_FAST  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_PRESS  = 3'd0,
      CSR_LONG_PRESS   = 3'd1,
      CSR_REPEAT_GAP   = 3'd2,
      CSR_MIN_EDGE_GAP = 3'd3,
      CSR_STALL        = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [TIME_W-1:0] short_press;
      logic [TIME_W-1:0] long_press;
      logic [TIME_W-1:0] repeat_gap;
      logic [TIME_W-1:0] min_edge_gap;
      logic [TIME_W-1:0] stall;
   } cfg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EDGE,
      S_TICK,
      S_RD,
      S_EVAL,
      S_WALK,
      S_EMIT
   } state_type;

endpackage

@@ rtl/bcd_if.sv @@
// Handshake channel interfaces: input items, result items and register writes.
interface bcd_req_if;
   import bcd_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic              pressed;
   logic [TIME_W-1:0] now_us;
   modport source (output valid, output cmd, output pressed, output now_us, input ready);
   modport sink   (input valid, input cmd, input pressed, input now_us, output ready);
endinterface

interface bcd_rsp_if;
   import bcd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [EV_W-1:0]      event_res;
   logic [CLK_CNT_W-1:0] click_count;
   logic [STAT_W-1:0]    status;
   logic                 last;
   modport source (output valid, output event_res, output click_count, output status,
                   output last, input ready);
   modport sink   (input valid, input event_res, input click_count, input status,
                   input last, output ready);
endinterface

interface bcd_csr_if;
   import bcd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TIME_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/button_click_decoder.sv @@
// Button click decoder: top level with the sequencer and the result register.
//
// Decodes press/release edges and periodic ticks, each stamped with a free-running
// 32-bit microsecond counter (all differences wrap modulo 2^32), into press, release,
// short/long press, and single/double/triple/repeat click events. One item is handled
// at a time. An edge's result is loaded in S_EDGE, the state after accept. A tick
// with no stored edges, or one that only checks the last edge time, passes S_TICK
// and, on a stall timeout, S_EMIT. A tick while the button is held, or right after
// one press/release pair, passes S_TICK, S_RD and S_EVAL (one edge-time RAM read)
// and may pass S_EVAL twice. A tick that closes a run of N stored edges (N even, 4
// or more) walks the stored edge times through the single read port of the
// edge-time RAM, one entry a cycle; a long release-to-press gap ends the walk early.
// Stalls on the result channel hold the sequencer in the state that loads the result.
// A new item is taken while the last result still waits in the output register. The
// edge-time RAM is not cleared: only entries below the current edge count are used.

module button_click_decoder (
   input logic      clock,
   input logic      reset,
   bcd_req_if.sink  req_ch,
   bcd_rsp_if.source rsp_ch,
   bcd_csr_if.sink  csr_ch
);
   import bcd_pkg::*;

   cfg_type cfg;

   // sequencer state
   state_type state_ff, state_in;

   // latched input item
   logic              pressed_ff, pressed_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // sequence state
   logic [IDX_W-1:0]  count_ff, count_in;
   logic              short_ff, short_in;
   logic              long_ff, long_in;
   logic [TIME_W-1:0] last_ff, last_in;

   // walk index, previous edge time, queued result
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [TIME_W-1:0] prev_ff, prev_in;
   event_type         res_ev_ff, res_ev_in;
   logic [CLK_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   status_type        res_st_ff, res_st_in;

   // result register
   logic                 rsp_valid_ff;
   logic [EV_W-1:0]      rsp_ev_ff;
   logic [CLK_CNT_W-1:0] rsp_cnt_ff;
   logic [STAT_W-1:0]    rsp_st_ff;
   logic                 rsp_last_ff;

   logic                 out_load;
   event_type            out_ev;
   logic [CLK_CNT_W-1:0] out_cnt;
   status_type           out_st;
   logic                 out_last;
   logic                 out_free;
   logic                 seq_clr;

   // edge-time RAM
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [IDX_W-1:0]  ram_raddr;
   logic [TIME_W-1:0] ram_rdata;

   // shared decode
   logic              accept;
   logic [TIME_W-1:0] diff_last, diff_rd, gap;
   logic              exp_kind, full, exp_kind2;
   logic [IDX_W-1:0]  cnt0;
   logic              cnt_zero, cnt_one, cnt_two, odd_big, even_big;
   logic              stall_hit, quiet_hit;
   logic              eval_s, eval_l, eval_two_emit;
   logic              walk_err, walk_end;
   event_type         click_ev;
   logic [CLK_CNT_W-1:0] click_cnt;

   bcd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bcd_ram #(
      .DEPTH (MAX_EDGES),
      .WIDTH (TIME_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (now_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_res   = rsp_ev_ff;
   assign rsp_ch.click_count = rsp_cnt_ff;
   assign rsp_ch.status      = rsp_st_ff;
   assign rsp_ch.last        = rsp_last_ff;

   assign diff_last = now_ff - last_ff;
   assign diff_rd   = now_ff - prev_ff;
   assign gap       = ram_rdata - prev_ff;

   // edge checks; a full store restarts the sequence before the edge is stored
   assign exp_kind  = pressed_ff ? !count_ff[0] : count_ff[0];
   assign full      = (count_ff >= IDX_W'(MAX_EDGES - 1));
   assign cnt0      = full ? '0 : count_ff;
   assign exp_kind2 = pressed_ff ? !cnt0[0] : cnt0[0];

   assign cnt_zero  = (count_ff == '0);
   assign cnt_one   = (count_ff == IDX_W'(1));
   assign cnt_two   = (count_ff == IDX_W'(2));
   assign odd_big   = count_ff[0] && !cnt_one;
   assign even_big  = !count_ff[0] && !cnt_zero && !cnt_two;
   assign stall_hit = (diff_last >= cfg.stall);
   assign quiet_hit = (diff_last >= cfg.repeat_gap);

   // held button (one edge) and single press/release pair
   assign eval_s        = (diff_rd >= cfg.short_press) && !short_ff;
   assign eval_l        = (diff_rd >= cfg.long_press);
   assign eval_two_emit = long_ff || short_ff || (diff_rd >= cfg.repeat_gap);

   // walk: at an even index the data is a press, prev holds the release before it
   assign walk_err  = !j_ff[0] && (gap >= cfg.repeat_gap);
   assign walk_end  = (j_ff == count_ff - IDX_W'(1));
   assign click_ev  = (count_ff == IDX_W'(4)) ? EV_DOUBLE :
                      (count_ff == IDX_W'(6)) ? EV_TRIPLE : EV_REPEAT;
   assign click_cnt = CLK_CNT_W'(count_ff >> 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_ch.cmd ? S_EDGE : S_TICK;
            end
         end
         S_EDGE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (cnt_one || cnt_two) begin
               state_in = S_RD;
            end else if (odd_big && stall_hit) begin
               state_in = S_EMIT;
            end else if (even_big && quiet_hit) begin
               state_in = S_WALK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD: state_in = S_EVAL;
         S_EVAL: begin
            if (cnt_one) begin
               if (eval_s) begin
                  if (out_free) begin
                     state_in = eval_l ? S_EVAL : S_IDLE;
                  end
               end else if (eval_l) begin
                  if (out_free) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end else if (eval_two_emit) begin
               if (out_free) begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (walk_err || walk_end) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and result selection
   always_comb begin
      pressed_in = pressed_ff;
      now_in     = now_ff;
      count_in   = count_ff;
      short_in   = short_ff;
      long_in    = long_ff;
      last_in    = last_ff;
      j_in       = j_ff;
      prev_in    = prev_ff;
      res_ev_in  = res_ev_ff;
      res_cnt_in = res_cnt_ff;
      res_st_in  = res_st_ff;
      out_load   = 1'b0;
      out_ev     = EV_NONE;
      out_cnt    = '0;
      out_st     = ST_OK;
      out_last   = 1'b1;
      seq_clr    = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = cnt0;
      ram_raddr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pressed_in = req_ch.pressed;
               now_in     = req_ch.now_us;
            end
         end
         S_EDGE: begin
            if (out_free) begin
               out_load = 1'b1;
               if (exp_kind && (diff_last < cfg.min_edge_gap)) begin
                  seq_clr = 1'b1;
                  out_st  = ST_FAST;
               end else if (!exp_kind2) begin
                  seq_clr = 1'b1;
                  out_ev  = pressed_ff ? EV_PRESS : EV_RELEASE;
                  out_st  = ST_SAME;
               end else begin
                  ram_we   = 1'b1;
                  count_in = cnt0 + IDX_W'(1);
                  last_in  = now_ff;
                  if (full) begin
                     short_in = 1'b0;
                     long_in  = 1'b0;
                  end
                  out_ev = pressed_ff ? EV_PRESS : EV_RELEASE;
               end
            end
         end
         S_TICK: begin
            ram_raddr  = cnt_one ? '0 : IDX_W'(1);
            j_in       = IDX_W'(1);
            res_ev_in  = EV_NONE;
            res_cnt_in = '0;
            res_st_in  = ST_STALL;
         end
         S_RD: begin
            prev_in = ram_rdata;
         end
         S_EVAL: begin
            if (cnt_one) begin
               if (eval_s) begin
                  out_load = out_free;
                  out_ev   = EV_SHORT_START;
                  out_last = !eval_l;
                  if (out_free) begin
                     short_in = 1'b1;
                  end
               end else if (eval_l) begin
                  out_load = out_free;
                  out_ev   = long_ff ? EV_LONG_HOLD : EV_LONG_START;
                  if (out_free) begin
                     long_in = 1'b1;
                  end
               end
            end else if (eval_two_emit) begin
               out_load = out_free;
               seq_clr  = out_free;
               if (long_ff) begin
                  out_ev = EV_LONG_END;
               end else if (short_ff) begin
                  out_ev = EV_SHORT_END;
               end else begin
                  out_ev  = EV_SINGLE;
                  out_cnt = CLK_CNT_W'(1);
               end
            end
         end
         S_WALK: begin
            prev_in   = ram_rdata;
            ram_raddr = j_ff + IDX_W'(1);
            if (walk_err) begin
               res_ev_in  = EV_NONE;
               res_cnt_in = '0;
               res_st_in  = ST_GAP;
            end else if (walk_end) begin
               res_ev_in  = click_ev;
               res_cnt_in = click_cnt;
               res_st_in  = ST_OK;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         S_EMIT: begin
            out_load = out_free;
            seq_clr  = out_free;
            out_ev   = res_ev_ff;
            out_cnt  = res_cnt_ff;
            out_st   = res_st_ff;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase

      // sequence restart
      if (seq_clr) begin
         count_in = '0;
         short_in = 1'b0;
         long_in  = 1'b0;
         last_in  = now_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         short_ff     <= 1'b0;
         long_ff      <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         short_ff <= short_in;
         long_ff  <= long_in;
         last_ff  <= last_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pressed_ff <= pressed_in;
      now_ff     <= now_in;
      j_ff       <= j_in;
      prev_ff    <= prev_in;
      res_ev_ff  <= res_ev_in;
      res_cnt_ff <= res_cnt_in;
      res_st_ff  <= res_st_in;
      if (out_load) begin
         rsp_ev_ff   <= out_ev;
         rsp_cnt_ff  <= out_cnt;
         rsp_st_ff   <= out_st;
         rsp_last_ff <= out_last;
      end
   end

endmodule

@@ rtl/bcd_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
module bcd_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/bcd_csr.sv @@
// Configuration registers: timing thresholds, written through the csr channel.
module bcd_csr (
   input  logic             clock,
   input  logic             reset,
   bcd_csr_if.sink          csr_ch,
   output bcd_pkg::cfg_type cfg
);
   import bcd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_SHORT_PRESS:  cfg_in.short_press  = csr_ch.data;
            CSR_LONG_PRESS:   cfg_in.long_press   = csr_ch.data;
            CSR_REPEAT_GAP:   cfg_in.repeat_gap   = csr_ch.data;
            CSR_MIN_EDGE_GAP: cfg_in.min_edge_gap = csr_ch.data;
            CSR_STALL:        cfg_in.stall        = csr_ch.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_press  <= SHORT_PRESS_RST;
         cfg_ff.long_press   <= LONG_PRESS_RST;
         cfg_ff.repeat_gap   <= REPEAT_GAP_RST;
         cfg_ff.min_edge_gap <= MIN_EDGE_GAP_RST;
         cfg_ff.stall        <= STALL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ verif/button_click_decoder_checker.sv @@
// Button click decoder scoreboard: predicts each input item's results and checks them.
module button_click_decoder_checker (
   input  logic clock,
   input  logic reset,
   bcd_req_if   req_ch,
   bcd_rsp_if   rsp_ch,
   bcd_csr_if   csr_ch,
   output int   error_count,
   output int   pending,
   output int   checked
);
   import bcd_pkg::*;

   typedef struct packed {
      event_type             ev;
      logic [CLK_CNT_W-1:0]  clicks;
      status_type            st;
      logic                  last;
   } click_result_type;

   cfg_type           cfg;
   logic [TIME_W-1:0] edge_times [MAX_EDGES];
   logic [IDX_W-1:0]  edge_count;
   logic              short_fired;
   logic              long_fired;
   logic [TIME_W-1:0] last_edge_time;

   click_result_type expected_results[$];
   click_result_type produced[$];

   initial begin
      error_count = 0;
      checked     = 0;
      pending     = 0;
   end

   function automatic void restart_run(input logic [TIME_W-1:0] now);
      edge_count     = '0;
      short_fired    = 1'b0;
      long_fired     = 1'b0;
      last_edge_time = now;
   endfunction

   function automatic void add_result(input event_type ev, input logic [CLK_CNT_W-1:0] clicks,
                                      input status_type st);
      produced.push_back('{ev, clicks, st, 1'b0});
   endfunction

   function automatic void decode_edge(input logic down, input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] since;
      logic              in_turn;
      since   = now - last_edge_time;
      in_turn = down ? !edge_count[0] : edge_count[0];
      if (in_turn && since < cfg.min_edge_gap) begin
         restart_run(now);
         add_result(EV_NONE, '0, ST_FAST);
         return;
      end
      // store full: start over, then judge the edge against an empty run
      if (edge_count >= MAX_EDGES - 1) restart_run(now);
      in_turn = down ? !edge_count[0] : edge_count[0];
      if (!in_turn) begin
         restart_run(now);
         add_result(down ? EV_PRESS : EV_RELEASE, '0, ST_SAME);
         return;
      end
      edge_times[edge_count] = now;
      edge_count     = edge_count + 1'b1;
      last_edge_time = now;
      add_result(down ? EV_PRESS : EV_RELEASE, '0, ST_OK);
   endfunction

   function automatic void decode_tick(input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      logic              gap_bad;
      event_type         ev;
      int                i;
      if (edge_count == 0) return;
      if (edge_count == 1) begin
         elapsed = now - edge_times[0];
         if (elapsed >= cfg.short_press && !short_fired) begin
            add_result(EV_SHORT_START, '0, ST_OK);
            short_fired = 1'b1;
         end
         if (elapsed >= cfg.long_press) begin
            if (!long_fired) begin
               add_result(EV_LONG_START, '0, ST_OK);
               long_fired = 1'b1;
            end else begin
               add_result(EV_LONG_HOLD, '0, ST_OK);
            end
         end
         return;
      end
      if (edge_count == 2) begin
         elapsed = now - edge_times[1];
         if (long_fired) begin
            add_result(EV_LONG_END, '0, ST_OK);
            restart_run(now);
         end else if (short_fired) begin
            add_result(EV_SHORT_END, '0, ST_OK);
            restart_run(now);
         end else if (elapsed >= cfg.repeat_gap) begin
            add_result(EV_SINGLE, CLK_CNT_W'(1), ST_OK);
            restart_run(now);
         end
         return;
      end
      elapsed = now - last_edge_time;
      if (!edge_count[0]) begin
         if (elapsed < cfg.repeat_gap) return;
         // every release-to-press gap of the run must be short
         gap_bad = 1'b0;
         for (i = 1; i + 1 < edge_count; i += 2) begin
            if (edge_times[i+1] - edge_times[i] >= cfg.repeat_gap) gap_bad = 1'b1;
         end
         if (gap_bad) begin
            add_result(EV_NONE, '0, ST_GAP);
         end else begin
            ev = (edge_count == 4) ? EV_DOUBLE : (edge_count == 6) ? EV_TRIPLE : EV_REPEAT;
            add_result(ev, CLK_CNT_W'(edge_count >> 1), ST_OK);
         end
         restart_run(now);
         return;
      end
      if (elapsed >= cfg.stall) begin
         restart_run(now);
         add_result(EV_NONE, '0, ST_STALL);
      end
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : watch
      click_result_type got;
      click_result_type want;
      if (reset) begin
         cfg.short_press  = SHORT_PRESS_RST;
         cfg.long_press   = LONG_PRESS_RST;
         cfg.repeat_gap   = REPEAT_GAP_RST;
         cfg.min_edge_gap = MIN_EDGE_GAP_RST;
         cfg.stall        = STALL_RST;
         restart_run('0);
         expected_results.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.event_res, rsp_ch.click_count, rsp_ch.status, rsp_ch.last};
            checked++;
            if (expected_results.size() == 0) begin
               flag_error($sformatf({"result event %0d count %0d status %0d last %0b, ",
                                     "none expected"},
                                    got.ev, got.clicks, got.st, got.last));
            end else begin
               want = expected_results.pop_front();
               if (got !== want)
                  flag_error($sformatf({"got event %0d count %0d status %0d last %0b, ",
                                        "expected event %0d count %0d status %0d last %0b"},
                                       got.ev, got.clicks, got.st, got.last,
                                       want.ev, want.clicks, want.st, want.last));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_SHORT_PRESS:  cfg.short_press  = csr_ch.data;
               CSR_LONG_PRESS:   cfg.long_press   = csr_ch.data;
               CSR_REPEAT_GAP:   cfg.repeat_gap   = csr_ch.data;
               CSR_MIN_EDGE_GAP: cfg.min_edge_gap = csr_ch.data;
               CSR_STALL:        cfg.stall        = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            produced.delete();
            if (req_ch.cmd) decode_edge(req_ch.pressed, req_ch.now_us);
            else decode_tick(req_ch.now_us);
            if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
            foreach (produced[k]) expected_results.push_back(produced[k]);
         end
      end
      pending = expected_results.size();
   end

endmodule

@@ verif/button_click_decoder_test.sv @@
// Button click decoder testbench top: clock, reset, stimulus, register phases and verdict.
module button_click_decoder_test;
   import bcd_pkg::*;

   // cmd field codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_EDGE = 1'b1;
   // index past the register list; writes there are dropped by the block
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = MAX_EDGES + 8;   // longest walk plus margin
   localparam int ITEMS_PER_PHASE = 130;
   localparam int PHASES          = 6;

   logic clock = 1'b0;
   logic reset;

   bcd_req_if req_ch ();
   bcd_rsp_if rsp_ch ();
   bcd_csr_if csr_ch ();

   int error_count;
   int pending;
   int checked;

   int                tx_idle_pct;
   int                rx_idle_pct;
   int                items_sent;
   int                cycles = 0;
   logic [TIME_W-1:0] stamp;   // running microsecond clock of the stimulus
   cfg_type           cfg;     // register values, used to aim the timing

   button_click_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   button_click_decoder_checker click_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .error_count (error_count),
      .pending     (pending),
      .checked     (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: random back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still pending", cycles, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // --- timing helpers --------------------------------------------------

   // at least lo and below hi; lo itself when there is no room; often a boundary
   function automatic logic [TIME_W-1:0] span(input logic [TIME_W-1:0] lo,
                                               input logic [TIME_W-1:0] hi);
      if (hi <= lo) return lo;
      if ($urandom_range(3) == 0) return ($urandom_range(1) != 0) ? lo : hi - 1;
      return $urandom_range(hi - 1, lo);
   endfunction

   // at least x (saturating), often exactly x
   function automatic logic [TIME_W-1:0] past(input logic [TIME_W-1:0] x);
      logic [TIME_W-1:0] pad;
      pad = ($urandom_range(2) == 0) ? '0 : $urandom_range(1000, 1);
      return (x > ~pad) ? '1 : x + pad;
   endfunction

   // --- channel drivers --------------------------------------------------
   // Each driver starts on a falling edge and returns on the rising edge that
   // took the item, so valid is never lowered and raised in one time step.

   task automatic send_item(input logic c, input logic p, input logic [TIME_W-1:0] t);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= c;
      req_ch.pressed <= p;
      req_ch.now_us  <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic button_edge(input logic down, input logic [TIME_W-1:0] after);
      stamp = stamp + after;
      send_item(CMD_EDGE, down, stamp);
   endtask

   // pressed is a don't-care on ticks, so it is randomized
   task automatic timer_tick(input logic [TIME_W-1:0] after);
      stamp = stamp + after;
      send_item(CMD_TICK, 1'($urandom_range(1)), stamp);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TIME_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_SHORT_PRESS:  cfg.short_press  = value;
         CSR_LONG_PRESS:   cfg.long_press   = value;
         CSR_REPEAT_GAP:   cfg.repeat_gap   = value;
         CSR_MIN_EDGE_GAP: cfg.min_edge_gap = value;
         CSR_STALL:        cfg.stall        = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [TIME_W-1:0] s_us, input logic [TIME_W-1:0] l_us,
                                 input logic [TIME_W-1:0] r_us, input logic [TIME_W-1:0] m_us,
                                 input logic [TIME_W-1:0] t_us);
      write_register(CSR_SHORT_PRESS, s_us);
      write_register(CSR_LONG_PRESS, l_us);
      write_register(CSR_REPEAT_GAP, r_us);
      write_register(CSR_MIN_EDGE_GAP, m_us);
      write_register(CSR_STALL, t_us);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Hold the input off until every expected result is back. With settle set,
   // also wait out a tick that may still be walking the store with no result.
   task automatic drain(input bit settle);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // --- random sequences ------------------------------------------------

   // an edge 'gap' after the last one, sometimes with a tick slipped in between
   task automatic edge_with_tick(input logic down, input logic [TIME_W-1:0] gap);
      logic [TIME_W-1:0] early;
      early = '0;
      if ($urandom_range(4) == 0) begin
         early = $urandom_range(gap);
         timer_tick(early);
      end
      button_edge(down, gap - early);
   endtask

   // press/release pairs, then a quiet tick that closes the run;
   // sloppy runs now and then leave a gap long enough to break the run
   task automatic click_run(input int clicks, input bit sloppy);
      logic [TIME_W-1:0] gap;
      int                k;
      for (k = 0; k < clicks; k++) begin
         if (k == 0) gap = past(cfg.min_edge_gap);
         else if (sloppy && $urandom_range(5) == 0) gap = past(cfg.repeat_gap);
         else gap = span(cfg.min_edge_gap, cfg.repeat_gap);
         edge_with_tick(1'b1, gap);
         edge_with_tick(1'b0, span(cfg.min_edge_gap, cfg.short_press));
      end
      timer_tick(past(cfg.repeat_gap));
   endtask

   // press, ticks walking the hold time across the short and long marks, release
   task automatic long_hold();
      logic [TIME_W-1:0] held;
      logic [TIME_W-1:0] goal;
      int                n;
      button_edge(1'b1, past(cfg.min_edge_gap));
      held = '0;
      n    = $urandom_range(4, 1);
      repeat (n) begin
         case ($urandom_range(3))
            0: goal = span(held, cfg.short_press);
            1: goal = past(cfg.short_press);
            2: goal = past(cfg.long_press);
            default: goal = past(held);
         endcase
         if (goal < held) goal = held;
         timer_tick(goal - held);
         held = goal;
      end
      button_edge(1'b0, $urandom_range(1000));
      timer_tick($urandom_range(1000));
      if ($urandom_range(1) != 0) timer_tick(past(cfg.repeat_gap));
   endtask

   // a run left hanging on a press, then quiet until the stall timeout
   task automatic stall_run();
      logic [TIME_W-1:0] wait_us;
      button_edge(1'b1, past(cfg.min_edge_gap));
      button_edge(1'b0, span(cfg.min_edge_gap, cfg.short_press));
      button_edge(1'b1, span(cfg.min_edge_gap, cfg.repeat_gap));
      wait_us = past(cfg.stall);
      if ($urandom_range(1) != 0) begin
         timer_tick(wait_us >> 1);
         wait_us = wait_us - (wait_us >> 1);
      end
      timer_tick(wait_us);
   endtask

   // unstructured items: random kind, random spacing, random jumps of the clock
   task automatic noise_burst();
      logic [TIME_W-1:0] delta;
      repeat ($urandom_range(6, 2)) begin
         if ($urandom_range(7) == 0) stamp = $urandom();
         delta = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2000);
         if ($urandom_range(1) != 0) button_edge(1'($urandom_range(1)), delta);
         else timer_tick(delta);
      end
   endtask

   task automatic random_sequence();
      int pick;
      // now and then the sender waits until every result is back
      if ($urandom_range(99) < 3) drain(1'b0);
      pick = $urandom_range(99);
      if (pick < 2) click_run($urandom_range(64, 63), 1'b0);   // fills or nearly fills the edge store
      else if (pick < 50)
         click_run(($urandom_range(3) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1),
                   $urandom_range(4) == 0);
      else if (pick < 70) long_hold();
      else if (pick < 80) stall_run();
      else noise_burst();
   endtask

   // --- main flow --------------------------------------------------------

   initial begin : stimulus
      int phase;
      int target;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_TICK;
      req_ch.pressed = 1'b0;
      req_ch.now_us  = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_SHORT_PRESS;
      csr_ch.data    = '0;
      tx_idle_pct    = 23;
      rx_idle_pct    = 63;
      items_sent     = 0;
      cfg.short_press  = SHORT_PRESS_RST;
      cfg.long_press   = LONG_PRESS_RST;
      cfg.repeat_gap   = REPEAT_GAP_RST;
      cfg.min_edge_gap = MIN_EDGE_GAP_RST;
      cfg.stall        = STALL_RST;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         // sender 23 / receiver 63, then swapped, then no idling at all
         tx_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 63 : 0;
         rx_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 23 : 0;

         if (phase == 0) begin
            // Directed part, reset settings. The clock starts at the top of its
            // range so the first press wraps it.
            stamp = '1;
            send_item(CMD_TICK, 1'b1, stamp);   // empty run: nothing to report
            button_edge(1'b1, 1000000);
            timer_tick(999999);                 // one short of the short mark
            timer_tick(1);                      // short start
            timer_tick(2000000);                // long start
            timer_tick(1);                      // long hold
            button_edge(1'b0, 10);
            timer_tick(5);                      // long end
            button_edge(1'b1, 3000000);
            timer_tick(3000000);                // short and long start from one tick
            button_edge(1'b0, 100);
            timer_tick(1);                      // long end
            button_edge(1'b1, 1000000);
            button_edge(1'b0, 999999);
            timer_tick(199999);                 // just inside the repeat gap
            timer_tick(1);                      // single click
            button_edge(1'b1, 1000);            // too fast after the run reset
            button_edge(1'b0, 10000);           // release with no press: same edge
            button_edge(1'b1, 10000);
            button_edge(1'b0, 10000);
            button_edge(1'b1, 250000);          // gap too long between clicks
            button_edge(1'b0, 10000);
            timer_tick(200000);                 // click gap error
            button_edge(1'b1, 10000);
            button_edge(1'b1, 10000);           // press twice: same edge
            drain(1'b0);
         end else begin
            drain(1'b1);
            case (phase)
               1: apply_settings(32'd2000, 32'd6000, 32'd800, 32'd50, 32'd3000);
               2: apply_settings('0, '0, '0, '0, '0);
               3: apply_settings('1, '1, '1, '1, '1);
               4: begin
                  write_register(CSR_SPARE, $urandom());
                  apply_settings($urandom_range(50000, 1), $urandom_range(100000, 1),
                                 $urandom_range(20000, 1), $urandom_range(2000),
                                 $urandom_range(100000, 1));
               end
               default: apply_settings(SHORT_PRESS_RST, LONG_PRESS_RST, REPEAT_GAP_RST,
                                       MIN_EDGE_GAP_RST, STALL_RST);
            endcase
         end

         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) random_sequence();
      end

      drain(1'b1);
      $display({"Sent %0d items over %0d register settings (zero and all-ones among them); ",
                "%0d results checked."}, items_sent, PHASES, checked);
      $display("Idle mix: sender 23%%/receiver 63%%, then 63%%/23%%, then none.");
      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results never arrived", error_count, pending);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
